>>> rtl/rd_pkg.sv
`default_nettype none
package rd_pkg;

  // default operand width
  localparam int WIDTH_DEF = 32;

  // control that travels along the cell chain with each item
  typedef struct packed {
    logic vld;
    logic dz;
  } ctl_t;

endpackage
`default_nettype wire

>>> rtl/rd_in_if.sv
`default_nettype none
interface rd_in_if #(parameter int WIDTH = rd_pkg::WIDTH_DEF) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] dividend;
  logic [WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface
`default_nettype wire

>>> rtl/rd_out_if.sv
`default_nettype none
interface rd_out_if #(parameter int WIDTH = rd_pkg::WIDTH_DEF) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] quotient;
  logic [WIDTH-1:0] remainder;
  logic             div_by_zero;

  modport source (output valid, output quotient, output remainder, output div_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/rd_cell.sv
`default_nettype none
module rd_cell #(
  parameter int WIDTH = rd_pkg::WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire rd_pkg::ctl_t     ctl_i,
  input  wire logic [WIDTH-1:0] q_i,
  input  wire logic [WIDTH-1:0] r_i,
  input  wire logic [WIDTH-1:0] d_i,
  output rd_pkg::ctl_t          ctl_o,
  output logic      [WIDTH-1:0] q_o,
  output logic      [WIDTH-1:0] r_o,
  output logic      [WIDTH-1:0] d_o
);
  import rd_pkg::*;

  ctl_t             ctl_r;
  logic [WIDTH-1:0] q_r, r_r, d_r;
  logic [WIDTH-1:0] q_nxt, r_nxt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             ge;

  // one shift-subtract-restore step on a width+1 bit partial remainder
  assign shifted = {r_i, q_i[WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d_i};
  assign ge      = ~diff[WIDTH+1];

  always_comb begin
    if (ge) begin
      r_nxt = diff[WIDTH-1:0];
      q_nxt = {q_i[WIDTH-2:0], 1'b1};
    end else begin
      r_nxt = shifted[WIDTH-1:0];
      q_nxt = {q_i[WIDTH-2:0], 1'b0};
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
      d_r <= d_i;
    end
  end

  assign ctl_o = ctl_r;
  assign q_o   = q_r;
  assign r_o   = r_r;
  assign d_o   = d_r;

endmodule
`default_nettype wire

>>> rtl/restoring_divider_top.sv
// unsigned restoring divider, one cell per quotient bit
// throughput: one item per cycle; the chain of WIDTH cells advances as a whole
// and holds while the last cell's result waits to be taken
// reset (synchronous, rst_n low) clears all valid bits; no item is invented
// across reset, and items in flight are dropped
`default_nettype none
module restoring_divider_top #(
  parameter int WIDTH = rd_pkg::WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  rd_in_if.sink    in_chan,
  rd_out_if.source out_chan
);
  import rd_pkg::*;

  ctl_t             ctl_s [0:WIDTH];
  logic [WIDTH-1:0] q_s   [0:WIDTH];
  logic [WIDTH-1:0] r_s   [0:WIDTH];
  logic [WIDTH-1:0] d_s   [0:WIDTH];
  logic [WIDTH-1:0] vld_vec;
  logic             adv;

  // whole chain moves when the last cell is empty or its item is taken
  assign adv           = ~ctl_s[WIDTH].vld | out_chan.ready;
  assign in_chan.ready = adv;

  // chain head fed from the input channel
  assign ctl_s[0].vld = in_chan.valid;
  assign ctl_s[0].dz  = (in_chan.divisor == '0);
  assign q_s[0]       = in_chan.dividend;
  assign r_s[0]       = '0;
  assign d_s[0]       = in_chan.divisor;

  // row of cells
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    rd_cell #(.WIDTH(WIDTH)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .ctl_i (ctl_s[i]),
      .q_i   (q_s[i]),
      .r_i   (r_s[i]),
      .d_i   (d_s[i]),
      .ctl_o (ctl_s[i+1]),
      .q_o   (q_s[i+1]),
      .r_o   (r_s[i+1]),
      .d_o   (d_s[i+1])
    );
    assign vld_vec[i] = ctl_s[i+1].vld;
  end

  // result from the last cell, zeroed on divide by zero
  assign out_chan.valid       = ctl_s[WIDTH].vld;
  assign out_chan.div_by_zero = ctl_s[WIDTH].dz;
  assign out_chan.quotient    = ctl_s[WIDTH].dz ? '0 : q_s[WIDTH];
  assign out_chan.remainder   = ctl_s[WIDTH].dz ? '0 : r_s[WIDTH];

  // remainder always below divisor for a real division
  a_rem_lt_div : assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_s[WIDTH].vld && !ctl_s[WIDTH].dz) |-> (r_s[WIDTH] < d_s[WIDTH]))
    else $error("remainder not below divisor");

  // an accepted item enters the first cell
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> ctl_s[1].vld)
    else $error("accepted item missing from first cell");

  // a stalled chain keeps every item in place
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_vec))
    else $error("chain moved while stalled");

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W            = rd_pkg::WIDTH_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int STALL_LIMIT  = 4000;

  // expected outcome of one division
  typedef struct packed {
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    logic         dz;
  } div_result_t;

  logic clk;
  logic rst_n;

  int unsigned send_idle_pct;
  int unsigned take_idle_pct;
  int unsigned quiet_cycles;

  rd_in_if  #(.WIDTH(W)) in_chan ();
  rd_out_if #(.WIDTH(W)) out_chan ();

  restoring_divider_top #(.WIDTH(W)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // restoring division with a W+1 bit partial remainder
  function automatic div_result_t divide(input logic [W-1:0] num, input logic [W-1:0] den);
    logic [W:0]   part;
    logic [W-1:0] quo;
    div_result_t  res;
    res = '0;
    if (den == '0) begin
      res.dz = 1'b1;
      return res;
    end
    part = '0;
    quo  = num;
    for (int i = 0; i < W; i++) begin
      part = {part[W-1:0], quo[W-1]};
      quo  = quo << 1;
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    res.quo = quo;
    res.rem = part[W-1:0];
    return res;
  endfunction

  // queue of pending results and the checks against them
  class div_scoreboard;
    div_result_t pending[$];
    int          n_errors;
    int          n_checked;
    int          n_zero_div;
    int          n_top_div;

    function new();
      n_errors   = 0;
      n_checked  = 0;
      n_zero_div = 0;
      n_top_div  = 0;
    endfunction

    function void note_input(logic [W-1:0] num, logic [W-1:0] den);
      pending.push_back(divide(num, den));
      if (den == '0) n_zero_div++;
      if (den[W-1]) n_top_div++;
    endfunction

    function void check_result(logic [W-1:0] quo, logic [W-1:0] rem, logic dz);
      div_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result quo=%h rem=%h dz=%b", $time, quo, rem, dz);
        n_errors++;
        return;
      end
      exp_res = pending.pop_front();
      n_checked++;
      if (quo !== exp_res.quo) begin
        $display("%0t: quotient expected %h actual %h", $time, exp_res.quo, quo);
        n_errors++;
      end
      if (rem !== exp_res.rem) begin
        $display("%0t: remainder expected %h actual %h", $time, exp_res.rem, rem);
        n_errors++;
      end
      if (dz !== exp_res.dz) begin
        $display("%0t: div_by_zero expected %b actual %b", $time, exp_res.dz, dz);
        n_errors++;
      end
    endfunction
  endclass

  div_scoreboard sb;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // monitor both channels and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) sb.note_input(in_chan.dividend, in_chan.divisor);
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result(out_chan.quotient, out_chan.remainder, out_chan.div_by_zero);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // present one division and wait until it is taken
  task automatic send_division(input logic [W-1:0] num, input logic [W-1:0] den);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid    <= 1'b0;
      in_chan.dividend <= $urandom;
      in_chan.divisor  <= $urandom;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.dividend <= num;
    in_chan.divisor  <= den;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // operand of random bit length so every magnitude shows up
  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] val;
    int unsigned  len;
    len = $urandom_range(W, 1);
    val = $urandom;
    return val >> (W - len);
  endfunction

  task automatic send_random_division();
    logic [W-1:0] num;
    logic [W-1:0] den;
    int unsigned  pick;
    pick = $urandom_range(99);
    num  = random_operand();
    den  = random_operand();
    if (pick < 4) begin
      // divide by zero
      den = '0;
    end else if (pick < 22) begin
      // divisor with its top bit set
      den[W-1] = 1'b1;
      if (pick < 12) num = num | ({W{1'b1}} << (W - 2));
    end else if (pick < 32) begin
      // dividend smaller than divisor
      if (den == '0) den = 1;
      num = num % den;
    end else if (pick < 40) begin
      case (pick % 3)
        0:       den = 1;
        1:       den = {W{1'b1}};
        default: den = {{(W-1){1'b1}}, 1'b0};
      endcase
    end
    send_division(num, den);
  endtask

  // stimulus
  initial begin
    sb               = new();
    send_idle_pct    = 13;
    take_idle_pct    = 77;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.dividend <= '0;
    in_chan.divisor  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases: zero divisor, unit and all-ones operands, top bit of divisor
    send_division('0, '0);
    send_division({W{1'b1}}, '0);
    send_division(32'h0000_0005, '0);
    send_division('0, 1);
    send_division({W{1'b1}}, 1);
    send_division({W{1'b1}}, {W{1'b1}});
    send_division({{(W-1){1'b1}}, 1'b0}, {W{1'b1}});
    send_division({W{1'b1}}, {{(W-1){1'b1}}, 1'b0});
    send_division({W{1'b1}}, {1'b1, {(W-1){1'b0}}});
    send_division({1'b1, {(W-1){1'b0}}}, {1'b1, {(W-2){1'b0}}, 1'b1});
    send_division({1'b0, {(W-1){1'b1}}}, {W{1'b1}});
    send_division(1, {W{1'b1}});
    send_division('0, {W{1'b1}});
    send_division({W{1'b1}}, 2);
    send_division(32'h0000_0007, 32'h0000_0003);
    send_division(32'h0000_0064, 32'h0000_000a);
    send_division(32'h1234_5678, 32'h0000_1234);
    send_division(32'hdead_beef, 32'h8000_0001);
    send_division(32'haaaa_aaaa, 32'h5555_5555);

    // random divisions across three idling regimes
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 77;
        take_idle_pct = 13;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      send_random_division();
    end
    in_chan.valid <= 1'b0;

    // drain and let the chain settle
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (W + 8) @(posedge clk);

    $display("checked %0d divisions: %0d by zero, %0d with divisor top bit set",
             sb.n_checked, sb.n_zero_div, sb.n_top_div);
    $display("idling covered slow sender, slow receiver and full rate");
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/rd_pkg.sv
rtl/rd_in_if.sv
rtl/rd_out_if.sv
rtl/rd_cell.sv
rtl/restoring_divider_top.sv
sim/testbench.sv
